@@ sv/adrc_pkg.sv @@
package adrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW = 40;               // working word
  localparam int WW = VW + 8;           // headroom for sums and short products
  localparam int MW = 2 * VW;           // full product / magnitude width
  localparam int NW = VW + FRAC_BITS;   // dividend width
  localparam int CW = 31;               // widest config register
  localparam int MUL_CNT_W = $clog2(VW + 1);
  localparam int DIV_CNT_W = $clog2(NW + 1);

  typedef logic signed [VW-1:0] val_t;
  typedef logic [VW-1:0] mag_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_PLANT_GAIN      = 3'd0;
  localparam reg_idx_t REG_SAMPLE_PERIOD   = 3'd1;
  localparam reg_idx_t REG_SETTLING_TIME   = 3'd2;
  localparam reg_idx_t REG_OBSERVER_FACTOR = 3'd3;
  localparam reg_idx_t REG_DRIVE_MIN       = 3'd4;
  localparam reg_idx_t REG_DRIVE_MAX       = 3'd5;

  localparam longint SMAX_L = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint X0_L = longint'(370) <<< FRAC_BITS;
  localparam longint X1_L = longint'(1000000) <<< FRAC_BITS;

  localparam val_t SMAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t SMIN = {1'b1, {(VW-1){1'b0}}};
  localparam val_t ONE = val_t'(longint'(1) <<< FRAC_BITS);
  localparam val_t NEG_SIX = val_t'(-(longint'(6) <<< FRAC_BITS));
  localparam val_t X0MAX = val_t'((X0_L > SMAX_L) ? SMAX_L : X0_L);
  localparam val_t X1MAX = val_t'((X1_L > SMAX_L) ? SMAX_L : X1_L);

  localparam logic [MW-1:0] MUL_RND = MW'(1) << (FRAC_BITS - 1);
  localparam int T_ROUND = 500;
  localparam int T_DIV = 1000;
  localparam int RATE_ROUND = 5;
  localparam int RATE_DIV = 10;

  localparam int SH_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int ROUND_DN = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;

  function automatic wide_t ext(input val_t v);
    return {{(WW-VW){v[VW-1]}}, v};
  endfunction

  function automatic val_t sat(input wide_t v);
    if (v > ext(SMAX)) return SMAX;
    else if (v < ext(SMIN)) return SMIN;
    else return v[VW-1:0];
  endfunction

  function automatic val_t add(input val_t a, input val_t b);
    return sat(ext(a) + ext(b));
  endfunction

  function automatic val_t vneg(input val_t a);
    return sat(-ext(a));
  endfunction

  function automatic mag_t mag(input val_t v);
    return v[VW-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic val_t from_mag(input logic [MW-1:0] m, input logic ng);
    logic big;
    big = |m[MW-1:VW-1];
    if (ng) return big ? SMIN : -val_t'(m[VW-1:0]);
    else return big ? SMAX : val_t'(m[VW-1:0]);
  endfunction

  function automatic val_t rshr1(input val_t v);
    logic [VW:0] s;
    s = {1'b0, mag(v)} + (VW+1)'(1);
    return from_mag(MW'(s >> 1), v[VW-1]);
  endfunction

  function automatic val_t trunc_int(input val_t v);
    mag_t mm;
    mm = mag(v);
    mm[FRAC_BITS-1:0] = '0;
    return from_mag(MW'(mm), v[VW-1]);
  endfunction

  // Q15.16 value to the working fraction
  function automatic val_t cvt16(input wide_t v);
    mag_t mm;
    logic [VW:0] s;
    mm = mag(sat(v));
    s = ({1'b0, mm} + (VW+1)'(ROUND_DN)) >> SH_DN;
    if (FRAC_BITS >= 16) return sat(v <<< SH_UP);
    else return from_mag(MW'(s), v[WW-1]);
  endfunction

  function automatic val_t clampv(input val_t v, input val_t lim);
    if (v > lim) return lim;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

endpackage

@@ sv/adrc_speed_controller.sv @@
// Speed controller, linear ADRC with a three-state extended state observer.
// Input channel (in_valid/in_ready): one request per sample tick, carrying
// the setpoint and the measured speed, both signed Q15.16.
// Result channel (out_valid/out_ready): one request per input, carrying the
// drive command (integer, truncated toward zero) and a flag that is set when
// clamping or rate limiting changed it.
// Config port (cfg_we/cfg_index/cfg_wdata): write while idle; any write to
// register 0 to 5 marks the derived gains stale, and the next sample
// first re-derives them and zeroes the observer state.
// Timing: all arithmetic goes through one bit-serial multiplier and one
// bit-serial divider, driven by a sequencer; the first sample after reset
// or a config write runs the derivation steps before its own update.
// One sample is in work at a time; in_ready is high while the sequencer idles.
// Reset clears the sequencer, marks gains stale and loads the register
// defaults. If the receiver stalls, the finished result holds in the output
// register; a new sample may be taken meanwhile, and its result waits in the
// last step until the register frees.
module adrc_speed_controller import adrc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_target_speed,
  input  logic signed [31:0]  in_measured_speed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_drive_command,
  output logic                out_limited,
  input  logic                cfg_we,
  input  reg_idx_t            cfg_index,
  input  logic [CW-1:0]       cfg_wdata
);

  // sequencer steps: derivation first, then the per-sample update
  localparam logic [5:0] ST_IDLE   = 6'd0;
  localparam logic [5:0] ST_D_T    = 6'd1;
  localparam logic [5:0] ST_D_SCL  = 6'd2;
  localparam logic [5:0] ST_D_SESO = 6'd3;
  localparam logic [5:0] ST_D_Q    = 6'd4;
  localparam logic [5:0] ST_D_SQ   = 6'd5;
  localparam logic [5:0] ST_D_G3   = 6'd6;
  localparam logic [5:0] ST_D_TG2  = 6'd7;
  localparam logic [5:0] ST_D_TG3  = 6'd8;
  localparam logic [5:0] ST_D_DET  = 6'd9;
  localparam logic [5:0] ST_D_M2   = 6'd10;
  localparam logic [5:0] ST_D_M5   = 6'd11;
  localparam logic [5:0] ST_D_KP   = 6'd12;
  localparam logic [5:0] ST_D_TB0  = 6'd13;
  localparam logic [5:0] ST_D_RATE = 6'd14;
  localparam logic [5:0] ST_D_O0   = 6'd15;
  localparam logic [5:0] ST_D_O1   = 6'd16;
  localparam logic [5:0] ST_D_O2   = 6'd17;
  localparam logic [5:0] ST_D_O3   = 6'd18;
  localparam logic [5:0] ST_D_O4   = 6'd19;
  localparam logic [5:0] ST_D_O5   = 6'd20;
  localparam logic [5:0] ST_D_O6   = 6'd21;
  localparam logic [5:0] ST_D_O7   = 6'd22;
  localparam logic [5:0] ST_D_O8   = 6'd23;
  localparam logic [5:0] ST_S_V0   = 6'd24;
  localparam logic [5:0] ST_S_V1A  = 6'd25;
  localparam logic [5:0] ST_S_V1B  = 6'd26;
  localparam logic [5:0] ST_S_V2A  = 6'd27;
  localparam logic [5:0] ST_S_V2B  = 6'd28;
  localparam logic [5:0] ST_S_N0   = 6'd29;
  localparam logic [5:0] ST_S_N1   = 6'd30;
  localparam logic [5:0] ST_S_N2   = 6'd31;
  localparam logic [5:0] ST_S_N3   = 6'd32;
  localparam logic [5:0] ST_S_N4   = 6'd33;
  localparam logic [5:0] ST_S_N5   = 6'd34;
  localparam logic [5:0] ST_S_N6   = 6'd35;
  localparam logic [5:0] ST_S_N7   = 6'd36;
  localparam logic [5:0] ST_S_N8   = 6'd37;
  localparam logic [5:0] ST_S_U0A  = 6'd38;
  localparam logic [5:0] ST_S_U0B  = 6'd39;
  localparam logic [5:0] ST_S_U    = 6'd40;
  localparam logic [5:0] ST_S_FIN  = 6'd41;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_MUL  = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  // control
  logic [5:0] st_r;
  logic busy_r, out_valid_r, derived_ok_r;

  // configuration
  logic [30:0] cfg_gain_r;
  logic [15:0] cfg_period_r;
  logic [30:0] cfg_settle_r;
  logic [6:0]  cfg_factor_r;
  logic signed [15:0] cfg_min_r, cfg_max_r;

  // derived gains and observer matrix
  val_t t_r, scl_r, seso_r, q_r, sq_r, g1_r, g2_r, g3_r, a_r, tg2_r, tg3_r, det_r;
  val_t kp_r, kd_r, tb0_r, rate_r;
  val_t om_r [9];

  // per-sample state
  val_t sp_r, y_r, acc_r, u0_r, u_r, raw_r, applied_r;
  val_t v_r [3];
  val_t est_r [3];

  // output register
  logic signed [15:0] out_cmd_r;
  logic out_lim_r;

  // arithmetic units
  logic mul_start, mul_done, div_start, div_done;
  val_t ma, mb, mul_res;
  logic [NW-1:0] div_num, div_quo;
  mag_t div_den;

  // step decode
  logic [1:0] kind;
  val_t qa, qb, op_res;
  logic dv_raw, dv_neg, dv_zero, rneg, fire, unit_done, fin_load;
  logic [NW-1:0] rnum;
  mag_t rden;
  val_t dv_zres;

  // misc combinational values
  val_t us, te, lo_v, hi_v, c1, c2;
  wide_t dw, dd;
  logic [WW-1:0] dw_mag;
  logic lim1, lim2;
  mag_t cm;
  logic signed [15:0] cmd;

  assign us = trunc_int(applied_r);
  assign te = add(tb0_r, rshr1(tb0_r));
  assign lo_v = val_t'(cfg_min_r) <<< FRAC_BITS;
  assign hi_v = val_t'(cfg_max_r) <<< FRAC_BITS;
  assign dw = ext(hi_v) - ext(lo_v);
  assign dw_mag = dw[WW-1] ? WW'(-dw) : WW'(dw);

  // operand selection for the step in hand
  always_comb begin
    kind = K_NONE;
    ma = '0;
    mb = '0;
    qa = '0;
    qb = '0;
    dv_raw = 1'b0;
    rnum = '0;
    rden = '0;
    rneg = 1'b0;
    unique case (st_r)
      ST_IDLE, ST_D_SESO, ST_S_FIN: begin
        kind = K_NONE;
      end
      ST_D_T: begin
        kind = K_DIV;
        dv_raw = 1'b1;
        rnum = (NW'(cfg_period_r) << FRAC_BITS) + NW'(T_ROUND);
        rden = mag_t'(T_DIV);
      end
      ST_D_SCL: begin
        kind = K_DIV;
        qa = NEG_SIX;
        qb = cvt16(wide_t'(cfg_settle_r));
      end
      ST_D_Q:    begin kind = K_MUL; ma = seso_r; mb = t_r; end
      ST_D_SQ:   begin kind = K_MUL; ma = q_r; mb = seso_r; end
      ST_D_G3:   begin kind = K_MUL; ma = sq_r; mb = seso_r; end
      ST_D_TG2:  begin kind = K_MUL; ma = t_r; mb = g2_r; end
      ST_D_TG3:  begin kind = K_MUL; ma = t_r; mb = g3_r; end
      ST_D_DET:  begin kind = K_MUL; ma = t_r; mb = tg3_r; end
      ST_D_M2:   begin kind = K_MUL; ma = t_r; mb = t_r; end
      ST_D_M5:   begin kind = K_MUL; ma = a_r; mb = t_r; end
      ST_D_KP:   begin kind = K_MUL; ma = scl_r; mb = scl_r; end
      ST_D_TB0:  begin kind = K_MUL; ma = t_r; mb = cvt16(wide_t'(cfg_gain_r)); end
      ST_D_RATE: begin
        kind = K_DIV;
        dv_raw = 1'b1;
        rnum = NW'(dw_mag) + NW'(RATE_ROUND);
        rden = mag_t'(RATE_DIV);
        rneg = dw[WW-1];
      end
      // observer matrix: cofactors over the determinant
      ST_D_O0: begin kind = K_DIV; qa = ONE; qb = det_r; end
      ST_D_O1: begin kind = K_DIV; qa = t_r; qb = det_r; end
      ST_D_O2: begin kind = K_DIV; qa = om_r[2]; qb = det_r; end
      ST_D_O3: begin kind = K_DIV; qa = vneg(add(g2_r, tg3_r)); qb = det_r; end
      ST_D_O4: begin kind = K_DIV; qa = a_r; qb = det_r; end
      ST_D_O5: begin kind = K_DIV; qa = om_r[5]; qb = det_r; end
      ST_D_O6: begin kind = K_DIV; qa = vneg(g3_r); qb = det_r; end
      ST_D_O7: begin kind = K_DIV; qa = vneg(tg3_r); qb = det_r; end
      ST_D_O8: begin kind = K_DIV; qa = add(a_r, tg2_r); qb = det_r; end
      // observer input vector
      ST_S_V0:  begin kind = K_MUL; ma = g1_r; mb = y_r; end
      ST_S_V1A: begin kind = K_MUL; ma = tb0_r; mb = us; end
      ST_S_V1B: begin kind = K_MUL; ma = g2_r; mb = y_r; end
      ST_S_V2A: begin kind = K_MUL; ma = g3_r; mb = y_r; end
      ST_S_V2B: begin kind = K_MUL; ma = te; mb = add(us, vneg(raw_r)); end
      // matrix times vector, one product per step
      ST_S_N0: begin kind = K_MUL; ma = om_r[0]; mb = v_r[0]; end
      ST_S_N1: begin kind = K_MUL; ma = om_r[1]; mb = v_r[1]; end
      ST_S_N2: begin kind = K_MUL; ma = om_r[2]; mb = v_r[2]; end
      ST_S_N3: begin kind = K_MUL; ma = om_r[3]; mb = v_r[0]; end
      ST_S_N4: begin kind = K_MUL; ma = om_r[4]; mb = v_r[1]; end
      ST_S_N5: begin kind = K_MUL; ma = om_r[5]; mb = v_r[2]; end
      ST_S_N6: begin kind = K_MUL; ma = om_r[6]; mb = v_r[0]; end
      ST_S_N7: begin kind = K_MUL; ma = om_r[7]; mb = v_r[1]; end
      ST_S_N8: begin kind = K_MUL; ma = om_r[8]; mb = v_r[2]; end
      // control law
      ST_S_U0A: begin kind = K_MUL; ma = kp_r; mb = add(sp_r, vneg(est_r[0])); end
      ST_S_U0B: begin kind = K_MUL; ma = kd_r; mb = est_r[1]; end
      ST_S_U: begin
        kind = K_DIV;
        qa = add(u0_r, vneg(est_r[2]));
        qb = cvt16(wide_t'(cfg_gain_r));
      end
      default: begin
        kind = K_NONE;
      end
    endcase
  end

  // divider front end: a zero divisor saturates toward the dividend's sign
  always_comb begin
    if (dv_raw) begin
      div_num = rnum;
      div_den = rden;
      dv_neg = rneg;
      dv_zero = 1'b0;
    end else begin
      div_num = {mag(qa), {FRAC_BITS{1'b0}}} + NW'(mag(qb) >> 1);
      div_den = mag(qb);
      dv_neg = qa[VW-1] ^ qb[VW-1];
      dv_zero = (qb == '0);
    end
    if (qa[VW-1]) dv_zres = SMIN;
    else if (qa != '0) dv_zres = SMAX;
    else dv_zres = '0;
  end

  assign unit_done = (kind == K_MUL) ? mul_done : div_done;
  assign fire = (kind == K_NONE) ? (st_r != ST_IDLE && st_r != ST_S_FIN)
              : (busy_r ? unit_done : (kind == K_DIV && dv_zero));
  assign mul_start = !busy_r && kind == K_MUL;
  assign div_start = !busy_r && kind == K_DIV && !dv_zero;

  always_comb begin
    if (kind == K_MUL) op_res = mul_res;
    else if (dv_zero) op_res = dv_zres;
    else op_res = from_mag(MW'(div_quo), dv_neg);
  end

  // final step: clamp, then rate-limit against the clamped value
  always_comb begin
    if (u_r < lo_v) c1 = lo_v;
    else if (u_r > hi_v) c1 = hi_v;
    else c1 = u_r;
    lim1 = (c1 != u_r);
    dd = ext(c1) - ext(applied_r);
    lim2 = 1'b1;
    if (dd > ext(rate_r)) c2 = add(applied_r, rate_r);
    else if (dd < -ext(rate_r)) c2 = add(applied_r, vneg(rate_r));
    else begin
      c2 = c1;
      lim2 = 1'b0;
    end
    cm = mag(c2) >> FRAC_BITS;
    if (c2[VW-1]) cmd = (cm > mag_t'(32768)) ? 16'sh8000 : -$signed(cm[15:0]);
    else cmd = (cm > mag_t'(32767)) ? 16'sh7fff : $signed(cm[15:0]);
  end

  assign fin_load = (st_r == ST_S_FIN) && (!out_valid_r || out_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
      derived_ok_r <= 1'b0;
      cfg_gain_r <= 31'd65536;
      cfg_period_r <= 16'd10;
      cfg_settle_r <= 31'd65536;
      cfg_factor_r <= 7'd5;
      cfg_min_r <= -16'sd255;
      cfg_max_r <= 16'sd255;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PLANT_GAIN:      cfg_gain_r <= cfg_wdata[30:0];
          REG_SAMPLE_PERIOD:   cfg_period_r <= cfg_wdata[15:0];
          REG_SETTLING_TIME:   cfg_settle_r <= cfg_wdata[30:0];
          REG_OBSERVER_FACTOR: cfg_factor_r <= cfg_wdata[6:0];
          REG_DRIVE_MIN:       cfg_min_r <= $signed(cfg_wdata[15:0]);
          REG_DRIVE_MAX:       cfg_max_r <= $signed(cfg_wdata[15:0]);
          default: ;
        endcase
        // drop the derived gains on any write to a real register
        if (cfg_index <= REG_DRIVE_MAX) derived_ok_r <= 1'b0;
      end

      if (fin_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (st_r == ST_IDLE) begin
        if (in_valid) st_r <= derived_ok_r ? ST_S_V0 : ST_D_T;
      end else if (st_r == ST_S_FIN) begin
        if (fin_load) st_r <= ST_IDLE;
      end else if (fire) begin
        st_r <= st_r + 6'd1;
        busy_r <= 1'b0;
        if (st_r == ST_D_O8) derived_ok_r <= 1'b1;
      end else if (mul_start || div_start) begin
        busy_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_valid) begin
      sp_r <= cvt16(wide_t'(in_target_speed));
      y_r <= cvt16(wide_t'(in_measured_speed));
    end
    if (fin_load) begin
      applied_r <= c2;
      raw_r <= u_r;
      out_cmd_r <= cmd;
      out_lim_r <= lim1 | lim2;
    end
    if (fire) begin
      case (st_r)
        ST_D_T:    t_r <= op_res;
        ST_D_SCL:  scl_r <= op_res;
        ST_D_SESO: seso_r <= sat(ext(scl_r) * $signed({1'b0, cfg_factor_r}));
        ST_D_Q:    q_r <= op_res;
        ST_D_SQ: begin
          sq_r <= op_res;
          g1_r <= sat(-(ext(q_r) + (ext(q_r) <<< 1)));
        end
        ST_D_G3: begin
          g3_r <= vneg(op_res);
          g2_r <= sat(ext(sq_r) + (ext(sq_r) <<< 1));
        end
        ST_D_TG2: begin
          tg2_r <= op_res;
          a_r <= add(ONE, g1_r);
        end
        ST_D_TG3:  tg3_r <= op_res;
        ST_D_DET:  det_r <= add(add(a_r, tg2_r), op_res);
        ST_D_M2:   om_r[2] <= op_res;
        ST_D_M5:   om_r[5] <= op_res;
        ST_D_KP: begin
          kp_r <= op_res;
          kd_r <= sat(-(ext(scl_r) <<< 1));
        end
        ST_D_TB0:  tb0_r <= op_res;
        ST_D_RATE: rate_r <= op_res;
        ST_D_O0:   om_r[0] <= op_res;
        ST_D_O1:   om_r[1] <= op_res;
        ST_D_O2:   om_r[2] <= op_res;
        ST_D_O3:   om_r[3] <= op_res;
        ST_D_O4:   om_r[4] <= op_res;
        ST_D_O5:   om_r[5] <= op_res;
        ST_D_O6:   om_r[6] <= op_res;
        ST_D_O7:   om_r[7] <= op_res;
        ST_D_O8: begin
          // fresh gains restart the observer and the command history
          om_r[8] <= op_res;
          est_r[0] <= '0;
          est_r[1] <= '0;
          est_r[2] <= '0;
          raw_r <= '0;
          applied_r <= '0;
        end
        ST_S_V0:  v_r[0] <= add(est_r[0], op_res);
        ST_S_V1A: v_r[1] <= add(est_r[1], op_res);
        ST_S_V1B: v_r[1] <= add(v_r[1], op_res);
        ST_S_V2A: v_r[2] <= add(est_r[2], op_res);
        ST_S_V2B: v_r[2] <= add(v_r[2], op_res);
        ST_S_N0:  acc_r <= op_res;
        ST_S_N1:  acc_r <= add(acc_r, op_res);
        ST_S_N2:  est_r[0] <= clampv(add(acc_r, op_res), X0MAX);
        ST_S_N3:  acc_r <= op_res;
        ST_S_N4:  acc_r <= add(acc_r, op_res);
        ST_S_N5:  est_r[1] <= clampv(add(acc_r, op_res), X1MAX);
        ST_S_N6:  acc_r <= op_res;
        ST_S_N7:  acc_r <= add(acc_r, op_res);
        ST_S_N8:  est_r[2] <= clampv(add(acc_r, op_res), X1MAX);
        ST_S_U0A: u0_r <= op_res;
        ST_S_U0B: u0_r <= add(u0_r, vneg(op_res));
        ST_S_U:   u_r <= op_res;
        default: ;
      endcase
    end
  end

  adrc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .res   (mul_res)
  );

  adrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive_command = out_cmd_r;
  assign out_limited = out_lim_r;

endmodule

@@ sv/adrc_mul.sv @@
module adrc_mul import adrc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t res
);

  logic [MUL_CNT_W-1:0] cnt_r;
  logic busy_r, done_r, neg_r;
  mag_t mc_r, hi_r, lo_r;
  val_t res_r;
  logic [VW:0] sum;

  // one multiplier bit per cycle, low half shifts out into lo_r
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= MUL_CNT_W'(VW);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - MUL_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r <= mag(a);
      lo_r <= mag(b);
      hi_r <= '0;
      neg_r <= a[VW-1] ^ b[VW-1];
    end else if (busy_r && cnt_r != '0) begin
      hi_r <= sum[VW:1];
      lo_r <= {sum[0], lo_r[VW-1:1]};
    end else if (busy_r) begin
      // round to nearest, ties away from zero, then saturate
      res_r <= from_mag(({hi_r, lo_r} + MUL_RND) >> FRAC_BITS, neg_r);
    end
  end

  assign done = done_r;
  assign res = res_r;

endmodule

@@ sv/adrc_div.sv @@
module adrc_div import adrc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  mag_t          den,
  output logic          done,
  output logic [NW-1:0] quo
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic busy_r, done_r;
  logic [NW-1:0] num_r;
  mag_t rem_r, den_r;
  logic [VW:0] r2, diff;
  logic ge;

  // restoring division, one quotient bit per cycle
  assign r2 = {rem_r, num_r[NW-1]};
  assign diff = r2 - {1'b0, den_r};
  assign ge = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(NW);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? diff[VW-1:0] : r2[VW-1:0];
      num_r <= {num_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo = num_r;

endmodule
